// ===== rtl/ptb_pkg.sv =====
// Shared types and constants of the periodic timer bank.
`default_nettype none

package ptb_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 24;
    localparam int IDX_W     = 4;
    localparam int ELAP_W    = 16;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;

    typedef struct packed {
        logic                 create;
        logic                 del;
        logic                 tick;
        logic                 clear;
        logic                 walk_go;
        logic [TIME_BITS-1:0] period;
        logic [IDX_W-1:0]     sel;
        logic [ELAP_W-1:0]    elapsed;
    } cell_cmd_t;

    typedef struct packed {
        logic grant;
        logic del_hit;
        logic emit;
        logic emit_last;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ptb_cell.sv =====
// One timer slot of the bank, linked to its neighbors by the claim, token and fire chains.
`default_nettype none

module ptb_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ptb_pkg::IDX_W-1:0] slot_idx,
    input  wire ptb_pkg::cell_cmd_t        cmd,
    input  wire logic                      claim_in,
    output logic                           claim_out,
    input  wire logic                      token_in,
    output logic                           token_out,
    input  wire logic                      fire_in,
    output logic                           fire_out,
    output ptb_pkg::cell_stat_t            stat
);

    logic                          in_use_reg;
    logic                          in_use_next;
    logic                          token_reg;
    logic [ptb_pkg::TIME_BITS-1:0] period_reg;
    logic [ptb_pkg::TIME_BITS-1:0] period_next;
    logic [ptb_pkg::TIME_BITS-1:0] remain_reg;
    logic [ptb_pkg::TIME_BITS-1:0] remain_next;
    logic [ptb_pkg::TIME_BITS-1:0] elapsed_ext;
    logic                          free;
    logic                          fire;

    assign free        = !in_use_reg;
    assign fire        = in_use_reg && (remain_reg == '0);
    assign claim_out   = claim_in || free;
    assign fire_out    = fire || fire_in;
    assign token_out   = token_reg && cmd.walk_go;
    assign elapsed_ext = ptb_pkg::TIME_BITS'(cmd.elapsed);

    always_comb
    begin
        stat.grant     = cmd.create && free && !claim_in;
        stat.del_hit   = cmd.del && in_use_reg && (cmd.sel == slot_idx);
        stat.emit      = token_reg && fire;
        stat.emit_last = token_reg && fire && !fire_in;

        in_use_next = in_use_reg;
        period_next = period_reg;
        remain_next = remain_reg;
        if (cmd.clear || stat.del_hit)
        begin
            in_use_next = 1'b0;
        end
        if (stat.grant)
        begin
            in_use_next = 1'b1;
            period_next = cmd.period;
            remain_next = cmd.period;
        end
        if (cmd.tick && in_use_reg && (remain_reg != '0))
        begin
            remain_next = (remain_reg > elapsed_ext) ? (remain_reg - elapsed_ext) : '0;
        end
        if (stat.emit)
        begin
            remain_next = period_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            token_reg  <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            token_reg  <= token_in;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        remain_reg <= remain_next;
    end

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_bank.sv =====
// Top level of the periodic timer bank: command decode, tick walk control and result register.
// Create, delete and clear-all give their single result in the cycle after acceptance and keep busy low.
// A tick is accepted and busy then stays high while a token walks the slot cells,
// one cell per cycle; busy ends once the token reaches the last firing slot, or at once if none fires.
// Each firing slot gives a result in the cycle after the token reaches it; the receiver cannot stall.
// Reset frees every slot and clears the strobe and the walk; period and count stores are not reset.
`default_nettype none

module periodic_timer_bank (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [23:0] period_ms,
    input  wire logic [3:0]  slot,
    input  wire logic [15:0] elapsed_ms,
    output logic             valid,
    output logic [1:0]       status,
    output logic [3:0]       slot_id,
    output logic             fired,
    output logic             last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [ptb_pkg::IDX_W-1:0]   pos_reg;
    logic [ptb_pkg::IDX_W-1:0]   pos_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [3:0]                  slot_id_reg;
    logic [3:0]                  slot_id_next;
    logic                        fired_reg;
    logic                        fired_next;
    logic                        last_reg;
    logic                        last_next;

    ptb_pkg::cell_cmd_t          cmd;
    ptb_pkg::cell_stat_t         stat [ptb_pkg::SLOTS];
    logic [ptb_pkg::SLOTS:0]     claim_chain;
    logic [ptb_pkg::SLOTS:0]     token_chain;
    logic [ptb_pkg::SLOTS:0]     fire_chain;
    logic                        accept;
    logic                        walking;
    logic                        any_emit;
    logic                        any_last;
    logic                        any_hit;
    logic [ptb_pkg::IDX_W-1:0]   grant_idx;
    logic                        walk_end;

    assign busy    = (state_reg == ST_WALK);
    assign accept  = start && !busy;
    assign walking = (state_reg == ST_WALK);

    always_comb
    begin
        cmd.create  = 1'b0;
        cmd.del     = 1'b0;
        cmd.tick    = 1'b0;
        cmd.clear   = 1'b0;
        cmd.period  = period_ms[ptb_pkg::TIME_BITS-1:0];
        cmd.sel     = slot;
        cmd.elapsed = elapsed_ms;
        if (accept)
        begin
            unique case (ptb_pkg::op_t'(op))
                ptb_pkg::OP_CREATE: cmd.create = 1'b1;
                ptb_pkg::OP_DELETE: cmd.del    = 1'b1;
                ptb_pkg::OP_TICK:   cmd.tick   = 1'b1;
                ptb_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
                default:            cmd.clear  = 1'b0;
            endcase
        end
        cmd.walk_go = walking && !walk_end;
    end

    assign claim_chain[0]              = 1'b0;
    assign token_chain[0]              = cmd.tick;
    assign fire_chain[ptb_pkg::SLOTS]  = 1'b0;

    for (genvar i = 0; i < ptb_pkg::SLOTS; i++)
    begin : g_cell
        ptb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot_idx  (ptb_pkg::IDX_W'(i)),
            .cmd       (cmd),
            .claim_in  (claim_chain[i]),
            .claim_out (claim_chain[i+1]),
            .token_in  (token_chain[i]),
            .token_out (token_chain[i+1]),
            .fire_in   (fire_chain[i+1]),
            .fire_out  (fire_chain[i]),
            .stat      (stat[i])
        );
    end

    always_comb
    begin
        any_emit  = 1'b0;
        any_last  = 1'b0;
        any_hit   = 1'b0;
        grant_idx = '0;
        for (int i = 0; i < ptb_pkg::SLOTS; i++)
        begin
            any_emit = any_emit || stat[i].emit;
            any_last = any_last || stat[i].emit_last;
            any_hit  = any_hit || stat[i].del_hit;
            if (stat[i].grant)
            begin
                grant_idx = grant_idx | ptb_pkg::IDX_W'(i);
            end
        end
    end

    // On the first walk cycle the fire chain still covers every slot, so it tells whether any fires.
    assign walk_end = walking && (((pos_reg == '0) && !fire_chain[0]) || any_last);

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        valid_next   = 1'b0;
        status_next  = ptb_pkg::STATUS_OK;
        slot_id_next = '0;
        fired_next   = 1'b0;
        last_next    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                pos_next = '0;
                if (cmd.create)
                begin
                    valid_next = 1'b1;
                    if (claim_chain[ptb_pkg::SLOTS])
                    begin
                        slot_id_next = 4'(grant_idx);
                    end
                    else
                    begin
                        status_next = ptb_pkg::STATUS_FULL;
                    end
                end
                if (cmd.del)
                begin
                    valid_next   = 1'b1;
                    slot_id_next = slot;
                    status_next  = any_hit ? ptb_pkg::STATUS_OK : ptb_pkg::STATUS_NOT_IN_USE;
                end
                if (cmd.clear)
                begin
                    valid_next = 1'b1;
                end
                if (cmd.tick)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                pos_next = pos_reg + ptb_pkg::IDX_W'(1);
                if (any_emit)
                begin
                    valid_next   = 1'b1;
                    slot_id_next = 4'(pos_reg);
                    fired_next   = 1'b1;
                    last_next    = any_last;
                end
                else if (walk_end)
                begin
                    valid_next = 1'b1;
                end
                if (walk_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        slot_id_reg <= slot_id_next;
        fired_reg   <= fired_next;
        last_reg    <= last_next;
    end

    assign valid   = valid_reg;
    assign status  = status_reg;
    assign slot_id = slot_id_reg;
    assign fired   = fired_reg;
    assign last    = last_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench of the periodic timer bank: directed and random commands checked against a predictor.
module testbench;
    import ptb_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [23:0] period;
        logic [3:0]  slot;
        logic [15:0] elapsed;
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_id;
        logic       fired;
        logic       last;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    op_t         op = OP_CREATE;
    logic [23:0] period_ms = '0;
    logic [3:0]  slot = '0;
    logic [15:0] elapsed_ms = '0;
    logic        valid;
    logic [1:0]  status;
    logic [3:0]  slot_id;
    logic        fired;
    logic        last;

    timer_cmd_t    pending_cmds[$];
    timer_result_t expected_timer_results[$];
    int            accepted_cmds = 0;
    int            error_count = 0;

    logic                 timer_armed  [SLOTS];
    logic [TIME_BITS-1:0] timer_period [SLOTS];
    logic [TIME_BITS-1:0] timer_left   [SLOTS];

    periodic_timer_bank i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .period_ms  (period_ms),
        .slot       (slot),
        .elapsed_ms (elapsed_ms),
        .valid      (valid),
        .status     (status),
        .slot_id    (slot_id),
        .fired      (fired),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic timer_result_t make_result(input logic [1:0] st, input logic [3:0] id,
                                                  input logic fire, input logic fin);
        timer_result_t r;
        r.status  = st;
        r.slot_id = id;
        r.fired   = fire;
        r.last    = fin;
        return r;
    endfunction

    task automatic predict_timer_results(input timer_cmd_t cmd);
        int free_slot;
        int fire_total;
        int fire_seen;
        logic [3:0] id;
        free_slot  = -1;
        fire_total = 0;
        fire_seen  = 0;
        case (cmd.op)
            OP_CREATE:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!timer_armed[i])
                        free_slot = i;
                end
                if (free_slot < 0)
                begin
                    expected_timer_results.push_back(make_result(STATUS_FULL, 4'd0, 1'b0, 1'b1));
                end
                else
                begin
                    id = free_slot[3:0];
                    timer_armed[free_slot]  = 1'b1;
                    timer_period[free_slot] = cmd.period[TIME_BITS-1:0];
                    timer_left[free_slot]   = cmd.period[TIME_BITS-1:0];
                    expected_timer_results.push_back(make_result(STATUS_OK, id, 1'b0, 1'b1));
                end
            end
            OP_DELETE:
            begin
                if (timer_armed[cmd.slot])
                begin
                    timer_armed[cmd.slot] = 1'b0;
                    expected_timer_results.push_back(make_result(STATUS_OK, cmd.slot, 1'b0, 1'b1));
                end
                else
                begin
                    expected_timer_results.push_back(
                        make_result(STATUS_NOT_IN_USE, cmd.slot, 1'b0, 1'b1));
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    timer_armed[i] = 1'b0;
                expected_timer_results.push_back(make_result(STATUS_OK, 4'd0, 1'b0, 1'b1));
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (timer_armed[i] && timer_left[i] != 0)
                        timer_left[i] = (timer_left[i] > cmd.elapsed) ?
                                        timer_left[i] - cmd.elapsed : '0;
                    if (timer_armed[i] && timer_left[i] == 0)
                        fire_total++;
                end
                if (fire_total == 0)
                    expected_timer_results.push_back(make_result(STATUS_OK, 4'd0, 1'b0, 1'b1));
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (timer_armed[i] && timer_left[i] == 0)
                    begin
                        id = i[3:0];
                        fire_seen++;
                        timer_left[i] = timer_period[i];
                        expected_timer_results.push_back(
                            make_result(STATUS_OK, id, 1'b1, fire_seen == fire_total));
                    end
                end
            end
        endcase
    endtask

    task automatic queue_cmd(input op_t o, input logic [23:0] p, input logic [3:0] s,
                             input logic [15:0] e);
        timer_cmd_t cmd;
        cmd.op      = o;
        cmd.period  = p;
        cmd.slot    = s;
        cmd.elapsed = e;
        pending_cmds.push_back(cmd);
    endtask

    always @(posedge clk)
    begin : driver
        logic take;
        logic pause;
        timer_cmd_t done;
        take  = start && !busy;
        pause = ($urandom_range(99) < 17) && !(accepted_cmds >= 120 && accepted_cmds < 220);
        if (rst_n)
        begin
            if (take)
            begin
                done = pending_cmds.pop_front();
                predict_timer_results(done);
                accepted_cmds++;
            end
            if (take || !start)
            begin
                if (pending_cmds.size() > 0 && !pause)
                begin
                    start      <= 1'b1;
                    op         <= pending_cmds[0].op;
                    period_ms  <= pending_cmds[0].period;
                    slot       <= pending_cmds[0].slot;
                    elapsed_ms <= pending_cmds[0].elapsed;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        timer_result_t want;
        if (rst_n && valid)
        begin
            if (expected_timer_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result: status %0d slot_id %0d fired %0d last %0d",
                             status, slot_id, fired, last);
            end
            else
            begin
                want = expected_timer_results.pop_front();
                if (status !== want.status || slot_id !== want.slot_id ||
                    fired !== want.fired || last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"Result mismatch: expected status %0d slot_id %0d fired %0d ",
                                  "last %0d, got status %0d slot_id %0d fired %0d last %0d"},
                                 want.status, want.slot_id, want.fired, want.last,
                                 status, slot_id, fired, last);
                end
            end
        end
    end

    initial
    begin
        int pick;
        logic [23:0] per;
        logic [15:0] el;
        for (int i = 0; i < SLOTS; i++)
            timer_armed[i] = 1'b0;

        queue_cmd(OP_TICK, 24'd0, 4'd0, 16'd5);
        queue_cmd(OP_DELETE, 24'd0, 4'd15, 16'd0);
        queue_cmd(OP_CREATE, 24'd0, 4'd0, 16'd0);
        queue_cmd(OP_CREATE, 24'hFFFFFF, 4'hF, 16'hFFFF);
        queue_cmd(OP_TICK, 24'd0, 4'd0, 16'd0);
        queue_cmd(OP_TICK, 24'hFFFFFF, 4'hF, 16'hFFFF);
        queue_cmd(OP_CREATE, 24'd3, 4'd0, 16'd0);
        queue_cmd(OP_TICK, 24'd0, 4'd0, 16'd2);
        queue_cmd(OP_TICK, 24'd0, 4'd0, 16'd7);
        for (int k = 3; k < SLOTS; k++)
            queue_cmd(OP_CREATE, 24'(k * 100 + 1), 4'd0, 16'd0);
        queue_cmd(OP_CREATE, 24'h800000, 4'd0, 16'd0);
        queue_cmd(OP_TICK, 24'd0, 4'd0, 16'hFFFF);
        queue_cmd(OP_DELETE, 24'd0, 4'd1, 16'd0);
        queue_cmd(OP_CLEAR, 24'hFFFFFF, 4'hF, 16'hFFFF);

        for (int n = 0; n < 360; n++)
        begin
            pick = $urandom_range(99);
            per  = ($urandom_range(9) == 0) ? 24'($urandom) :
                   ($urandom_range(4) == 0) ? 24'($urandom_range(300)) :
                                              24'($urandom_range(20));
            el   = ($urandom_range(9) == 0) ? 16'($urandom) :
                   ($urandom_range(3) == 0) ? 16'($urandom_range(100)) :
                                              16'($urandom_range(10));
            if (pick < 35)
                queue_cmd(OP_CREATE, per, 4'($urandom), el);
            else if (pick < 57)
                queue_cmd(OP_DELETE, per, 4'($urandom), el);
            else if (pick < 97)
                queue_cmd(OP_TICK, per, 4'($urandom), el);
            else
                queue_cmd(OP_CLEAR, per, 4'($urandom), el);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        while (expected_timer_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ptb_pkg.sv
rtl/ptb_cell.sv
rtl/periodic_timer_bank.sv
tb/sv/testbench.sv
